### rtl/sorted_array_priority_queue_defines.svh
// Assertion macros used by the checker file of the sorted-array priority queue.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SAQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("Same-cycle check failed.");

// Next-cycle implication, checked outside reset.
`define SAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("Next-cycle check failed.");

`endif

### rtl/saq_pkg.sv
// Package with request, response types and codes of the sorted-array priority queue.
`default_nettype none
package saq_pkg;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic [3:0]         occupancy;
		logic               is_empty;
	} rsp_t;

endpackage
`default_nettype wire

### rtl/saq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module saq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

### rtl/saq_seq.sv
// Sequencer that inserts or removes one entry with a shared compare and RAM port pair.
`default_nettype none
module saq_seq #(
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire saq_pkg::req_t         req,
	output logic                       idle,
	output logic                       rsp_valid,
	output saq_pkg::rsp_t              rsp,
	input  wire logic                  rsp_take,
	output logic                       ram_rd_en,
	output logic        [AW-1:0]       ram_rd_addr,
	input  wire logic signed [31:0]    ram_rd_data,
	output logic                       ram_wr_en,
	output logic        [AW-1:0]       ram_wr_addr,
	output logic signed [31:0]         ram_wr_data
);
	import saq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CHK,
		ST_INS_CMP,
		ST_REM_CAP,
		ST_SHF_CHK,
		ST_SHF_WR,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   idx_dec;
	logic signed [31:0] val_q;
	logic signed [31:0] removed_q;
	logic [1:0]         status_q;
	logic               less;

	assign idx_dec = idx_q - 1'b1;
	assign less    = ram_rd_data < val_q;

	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = val_q;
		case (state_q)
			ST_IDLE: begin
				if (start && req.kind == KIND_REMOVE && cnt_q != '0) begin
					ram_rd_en = 1'b1;
				end
			end
			ST_INS_CHK: begin
				if (idx_q == '0) begin
					ram_wr_en = 1'b1;
				end else begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = idx_dec[AW-1:0];
				end
			end
			ST_INS_CMP: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = idx_q[AW-1:0];
				ram_wr_data = less ? ram_rd_data : val_q;
			end
			ST_SHF_CHK: begin
				if (idx_q != cnt_q) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = idx_q[AW-1:0];
				end
			end
			ST_SHF_WR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = idx_dec[AW-1:0];
				ram_wr_data = ram_rd_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			val_q     <= '0;
			removed_q <= '0;
			status_q  <= STATUS_DONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						val_q     <= req.value;
						removed_q <= '0;
						status_q  <= STATUS_DONE;
						if (req.kind == KIND_INSERT) begin
							if (cnt_q == CNT_W'(DEPTH)) begin
								status_q <= STATUS_FULL;
								state_q  <= ST_DONE;
							end else begin
								idx_q   <= cnt_q;
								state_q <= ST_INS_CHK;
							end
						end else begin
							if (cnt_q == '0) begin
								status_q <= STATUS_EMPTY;
								state_q  <= ST_DONE;
							end else begin
								idx_q   <= CNT_W'(1);
								state_q <= ST_REM_CAP;
							end
						end
					end
				end
				ST_INS_CHK: begin
					if (idx_q == '0) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (less) begin
						idx_q   <= idx_dec;
						state_q <= ST_INS_CHK;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_REM_CAP: begin
					removed_q <= ram_rd_data;
					state_q   <= ST_SHF_CHK;
				end
				ST_SHF_CHK: begin
					if (idx_q == cnt_q) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SHF_WR;
					end
				end
				ST_SHF_WR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_SHF_CHK;
				end
				ST_DONE: begin
					if (rsp_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle              = (state_q == ST_IDLE);
	assign rsp_valid         = (state_q == ST_DONE);
	assign rsp.status        = status_q;
	assign rsp.removed_value = removed_q;
	assign rsp.occupancy     = 4'(cnt_q);
	assign rsp.is_empty      = (cnt_q == '0);

endmodule
`default_nettype wire

### rtl/sorted_array_priority_queue.sv
// Top level of the bounded max-priority queue kept as a sorted array in RAM.
//
//   Channel   Direction   Handshake               Payload
//   in        input       in_valid / in_ready     saq_pkg::req_t (kind, value)
//   out       output      out_valid / out_ready   saq_pkg::rsp_t (status, removed_value,
//                                                 occupancy, is_empty)
//
// An insert shifts each smaller entry up by one place, reading and then writing one entry
// at a time; a remove reads the head and shifts every later entry down the same way.
// Both go through the single RAM read port; a full or empty request is rejected without RAM access.
// After reset the queue is empty and in_ready is high, so a request can be taken.
// in_ready stays low while a request is in work or its result waits for the output register.
`default_nettype none
module sorted_array_priority_queue #(
	parameter int DEPTH = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire saq_pkg::req_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output saq_pkg::rsp_t       out_data
);
	import saq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic               seq_idle;
	logic               seq_rsp_valid;
	rsp_t               seq_rsp;
	logic               take;
	logic               out_valid_q;
	rsp_t               out_data_q;
	logic               ram_rd_en;
	logic [AW-1:0]      ram_rd_addr;
	logic signed [31:0] ram_rd_data;
	logic               ram_wr_en;
	logic [AW-1:0]      ram_wr_addr;
	logic signed [31:0] ram_wr_data;

	assign in_ready = seq_idle;
	assign take     = seq_rsp_valid && (!out_valid_q || out_ready);

	saq_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_valid && in_ready),
		.req         (in_data),
		.idle        (seq_idle),
		.rsp_valid   (seq_rsp_valid),
		.rsp         (seq_rsp),
		.rsp_take    (take),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data)
	);

	saq_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= seq_rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

### rtl/saq_checker.sv
// Port-level checker for the sorted-array priority queue and its bind statement.
`default_nettype none
`include "sorted_array_priority_queue_defines.svh"
module saq_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire saq_pkg::req_t in_data,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire saq_pkg::rsp_t out_data
);
	import saq_pkg::*;

	logic in_seen;

	assign in_seen = in_valid && (in_data.kind == KIND_INSERT || in_data.kind == KIND_REMOVE);

	`SAQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`SAQ_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_seen && in_ready, !in_ready)
	`SAQ_ASSERT_NOW(a_empty_reject, clk, arst_n, out_valid && out_data.status == STATUS_EMPTY, out_data.is_empty && out_data.removed_value == 32'sd0)
	`SAQ_ASSERT_NOW(a_full_reject, clk, arst_n, out_valid && out_data.status == STATUS_FULL, !out_data.is_empty && out_data.removed_value == 32'sd0)

endmodule

bind sorted_array_priority_queue saq_checker u_saq_checker (.*);
`default_nettype wire
